[rtl/fdbvp_pkg.sv]
// Shared types, constants and fixed-point helpers for the boundary value solver.
// Depends on nothing; the multiplier, divider and top refer to it by scoped names.
package fdbvp_pkg;

   localparam int POINTS    = 20;
   localparam int FRAC_BITS = 16;
   localparam int QW        = 48;
   localparam int IDX_W     = $clog2(POINTS);
   localparam int PROD_W    = 2 * QW;
   localparam int CHUNK_W   = 16;
   localparam int NCHUNK    = QW / CHUNK_W;
   localparam int DVD_W     = QW + FRAC_BITS;
   localparam int DCNT_W    = $clog2(DVD_W + 1);

   typedef logic signed [QW-1:0] q_type;

   localparam q_type Q_ONE     = q_type'(QW'(1) << FRAC_BITS);
   localparam q_type Q_NEG_TWO = q_type'(QW'(0) - (QW'(2) << FRAC_BITS));

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FAIL = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_H2,
      ST_SET_T,
      ST_SET_R,
      ST_ELIM_INV,
      ST_ELIM_RHS,
      ST_BACK_RD,
      ST_BACK_DIV,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_HOLD,
      ST_FAIL_HOLD
   } fsm_type;

   typedef struct packed {
      logic  start;
      q_type a;
      q_type b;
   } op_req_type;

   typedef struct packed {
      logic  done;
      logic  sat;
      q_type value;
   } op_rsp_type;

   function automatic logic [QW-1:0] magnitude(q_type v);
      return v[QW-1] ? (QW'(0) - QW'(v)) : QW'(v);
   endfunction

   // Apply sign to a magnitude, saturating at the 48-bit limits: {sat, value}
   function automatic logic [QW:0] sign_sat(logic [PROD_W-1:0] m, logic neg);
      logic [PROD_W-1:0] lim;
      logic [QW-1:0]     mc;
      logic              s;
      lim = neg ? (PROD_W'(1) << (QW-1)) : ((PROD_W'(1) << (QW-1)) - PROD_W'(1));
      s   = m > lim;
      mc  = s ? lim[QW-1:0] : m[QW-1:0];
      return {s, (neg ? (QW'(0) - mc) : mc)};
   endfunction

   // a - b saturated to 48 bits: {sat, value}
   function automatic logic [QW:0] sat_sub(q_type a, q_type b);
      logic [QW:0] d;
      d = {a[QW-1], a} - {b[QW-1], b};
      if (d[QW] != d[QW-1]) begin
         return {1'b1, (d[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}})};
      end
      return {1'b0, d[QW-1:0]};
   endfunction

endpackage

[rtl/fdbvp_req_if.sv]
// Request channel: boundary values, start time and grid step with valid/ready.
// Depends on nothing.
interface fdbvp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] left_boundary;
   logic [31:0] right_boundary;
   logic [31:0] start_time;
   logic [30:0] step;

   modport source (output valid, left_boundary, right_boundary, start_time, step,
                   input ready);
   modport sink   (input valid, left_boundary, right_boundary, start_time, step,
                   output ready);
endinterface

[rtl/fdbvp_rsp_if.sv]
// Response channel: one solved grid point per transfer with valid/ready.
// Depends on nothing.
interface fdbvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  point_index;
   logic [31:0] point_value;
   logic        last_point;
   logic [1:0]  status;

   modport source (output valid, point_index, point_value, last_point, status,
                   input ready);
   modport sink   (input valid, point_index, point_value, last_point, status,
                   output ready);
endinterface

[rtl/fdbvp_mul.sv]
// Multi-cycle Q-format multiplier: 48x16 partial products accumulated over cycles.
// Depends on fdbvp_pkg.
module fdbvp_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  fdbvp_pkg::op_req_type op_req,
   output fdbvp_pkg::op_rsp_type op_rsp
);

   logic                                          busy_ff;
   logic                                          done_ff;
   logic [1:0]                                    cnt_ff;
   logic [fdbvp_pkg::QW-1:0]                      ua_ff;
   logic [fdbvp_pkg::QW-1:0]                      ub_ff;
   logic                                          neg_ff;
   logic [fdbvp_pkg::QW+fdbvp_pkg::CHUNK_W-1:0]   prod_ff;
   logic [fdbvp_pkg::PROD_W-1:0]                  acc_ff;
   logic [fdbvp_pkg::CHUNK_W-1:0]                 chunk;
   logic [fdbvp_pkg::QW:0]                        res;

   assign chunk = fdbvp_pkg::CHUNK_W'(ub_ff >> (fdbvp_pkg::CHUNK_W * int'(cnt_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (op_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (int'(cnt_ff) == fdbvp_pkg::NCHUNK) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_req.start) begin
         ua_ff  <= fdbvp_pkg::magnitude(op_req.a);
         ub_ff  <= fdbvp_pkg::magnitude(op_req.b);
         neg_ff <= op_req.a[fdbvp_pkg::QW-1] ^ op_req.b[fdbvp_pkg::QW-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (int'(cnt_ff) != fdbvp_pkg::NCHUNK) begin
            prod_ff <= ua_ff * chunk;
         end
         if (cnt_ff != 2'd0) begin
            acc_ff <= acc_ff + (fdbvp_pkg::PROD_W'(prod_ff)
                                << (fdbvp_pkg::CHUNK_W * (int'(cnt_ff) - 1)));
         end
      end
   end

   assign res = fdbvp_pkg::sign_sat(acc_ff >> fdbvp_pkg::FRAC_BITS, neg_ff);

   assign op_rsp.done  = done_ff;
   assign op_rsp.sat   = res[fdbvp_pkg::QW];
   assign op_rsp.value = res[fdbvp_pkg::QW-1:0];

endmodule

[rtl/fdbvp_div.sv]
// Restoring Q-format divider, one quotient bit per cycle, (a << FRAC_BITS) / b.
// Depends on fdbvp_pkg.
module fdbvp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fdbvp_pkg::op_req_type op_req,
   output fdbvp_pkg::op_rsp_type op_rsp
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [fdbvp_pkg::DCNT_W-1:0]      cnt_ff;
   logic [fdbvp_pkg::QW-1:0]          ub_ff;
   logic                              neg_ff;
   logic [fdbvp_pkg::DVD_W-1:0]       dvd_ff;
   logic [fdbvp_pkg::DVD_W-1:0]       quo_ff;
   logic [fdbvp_pkg::QW:0]            rem_ff;
   logic [fdbvp_pkg::QW:0]            rem_sh;
   logic                              ge;
   logic [fdbvp_pkg::QW:0]            res;

   assign rem_sh = {rem_ff[fdbvp_pkg::QW-1:0], dvd_ff[fdbvp_pkg::DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, ub_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (op_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= fdbvp_pkg::DCNT_W'(fdbvp_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - fdbvp_pkg::DCNT_W'(1);
            if (cnt_ff == fdbvp_pkg::DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_req.start) begin
         ub_ff  <= fdbvp_pkg::magnitude(op_req.b);
         neg_ff <= op_req.a[fdbvp_pkg::QW-1] ^ op_req.b[fdbvp_pkg::QW-1];
         dvd_ff <= {fdbvp_pkg::magnitude(op_req.a), {fdbvp_pkg::FRAC_BITS{1'b0}}};
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, ub_ff}) : rem_sh;
         quo_ff <= {quo_ff[fdbvp_pkg::DVD_W-2:0], ge};
         dvd_ff <= dvd_ff << 1;
      end
   end

   assign res = fdbvp_pkg::sign_sat(fdbvp_pkg::PROD_W'(quo_ff), neg_ff);

   assign op_rsp.done  = done_ff;
   assign op_rsp.sat   = res[fdbvp_pkg::QW];
   assign op_rsp.value = res[fdbvp_pkg::QW-1:0];

endmodule

[rtl/finite_difference_bvp_solver_top.sv]
// Tridiagonal finite-difference solver for x'' = t^2; sequencer and two row memories.
// Depends on fdbvp_pkg, fdbvp_req_if, fdbvp_rsp_if, fdbvp_mul, fdbvp_div.
// The one-bit-per-cycle divider is used 3*POINTS-2 times in sequence per request.
// One request is in flight at a time; the next is taken after its last result.
// Synchronous reset returns the sequencer to idle; row memories are not cleared.
module finite_difference_bvp_solver_top (
   input  logic               clock,
   input  logic               reset,
   fdbvp_req_if.sink          req_if,
   fdbvp_rsp_if.source        rsp_if
);

   fdbvp_pkg::fsm_type              state_ff, state_in;
   logic                            pend_ff, pend_in;
   logic [fdbvp_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                            sat_ff, sat_in;
   fdbvp_pkg::q_type                x1_ff, x1_in, x2_ff, x2_in;
   fdbvp_pkg::q_type                t_ff, t_in, h_ff, h_in, h2_ff, h2_in, tt_ff, tt_in;
   fdbvp_pkg::q_type                d_ff, d_in, dnew_ff, dnew_in, rprev_ff, rprev_in;
   fdbvp_pkg::q_type                nxt_ff, nxt_in;
   logic [5:0]                      rsp_idx_ff, rsp_idx_in;
   logic [31:0]                     rsp_val_ff, rsp_val_in;
   logic                            rsp_last_ff, rsp_last_in;
   fdbvp_pkg::status_type           rsp_stat_ff, rsp_stat_in;

   fdbvp_pkg::q_type                diag_mem [fdbvp_pkg::POINTS];
   fdbvp_pkg::q_type                rhs_mem  [fdbvp_pkg::POINTS];
   fdbvp_pkg::q_type                diag_rd_ff, rhs_rd_ff;
   logic                            mem_we;
   logic [fdbvp_pkg::IDX_W-1:0]     mem_wa, mem_ra;
   fdbvp_pkg::q_type                diag_wd, rhs_wd;

   fdbvp_pkg::op_req_type           mul_req, div_req;
   fdbvp_pkg::op_rsp_type           mul_rsp, div_rsp;

   fdbvp_mul u_mul (.clock(clock), .reset(reset), .op_req(mul_req), .op_rsp(mul_rsp));
   fdbvp_div u_div (.clock(clock), .reset(reset), .op_req(div_req), .op_rsp(div_rsp));

   localparam logic [fdbvp_pkg::IDX_W-1:0] LAST_IDX = fdbvp_pkg::IDX_W'(fdbvp_pkg::POINTS - 1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         diag_mem[mem_wa] <= diag_wd;
         rhs_mem[mem_wa]  <= rhs_wd;
      end
      diag_rd_ff <= diag_mem[mem_ra];
      rhs_rd_ff  <= rhs_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdbvp_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         nxt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         nxt_ff   <= nxt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      sat_ff      <= sat_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      h_ff        <= h_in;
      h2_ff       <= h2_in;
      tt_ff       <= tt_in;
      d_ff        <= d_in;
      dnew_ff     <= dnew_in;
      rprev_ff    <= rprev_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      logic [fdbvp_pkg::QW:0] sr;
      fdbvp_pkg::q_type       r;
      fdbvp_pkg::q_type       x;
      logic                   in_range;

      state_in    = state_ff;
      pend_in     = pend_ff;
      idx_in      = idx_ff;
      sat_in      = sat_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      t_in        = t_ff;
      h_in        = h_ff;
      h2_in       = h2_ff;
      tt_in       = tt_ff;
      d_in        = d_ff;
      dnew_in     = dnew_ff;
      rprev_in    = rprev_ff;
      nxt_in      = nxt_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      rsp_stat_in = rsp_stat_ff;
      mul_req     = '0;
      div_req     = '0;
      mem_we      = 1'b0;
      mem_wa      = idx_ff;
      mem_ra      = idx_ff;
      diag_wd     = fdbvp_pkg::Q_NEG_TWO;
      rhs_wd      = '0;
      sr          = '0;
      r           = '0;
      x           = '0;
      in_range    = 1'b0;
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;

      case (state_ff)
         fdbvp_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               x1_in  = fdbvp_pkg::q_type'($signed(req_if.left_boundary));
               x2_in  = fdbvp_pkg::q_type'($signed(req_if.right_boundary));
               t_in   = fdbvp_pkg::q_type'($signed(req_if.start_time));
               h_in   = fdbvp_pkg::q_type'({1'b0, req_if.step});
               sat_in = 1'b0;
               if (req_if.step == 31'd0) begin
                  rsp_idx_in  = 6'd0;
                  rsp_val_in  = 32'd0;
                  rsp_last_in = 1'b1;
                  rsp_stat_in = fdbvp_pkg::STATUS_FAIL;
                  state_in    = fdbvp_pkg::ST_FAIL_HOLD;
               end else begin
                  state_in = fdbvp_pkg::ST_H2;
               end
            end
         end
         fdbvp_pkg::ST_H2: begin
            mul_req = '{start: !pend_ff, a: h_ff, b: h_ff};
            pend_in = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               h2_in    = mul_rsp.value;
               sat_in   = sat_ff | mul_rsp.sat;
               t_in     = t_ff + h_ff;
               idx_in   = '0;
               state_in = fdbvp_pkg::ST_SET_T;
            end
         end
         fdbvp_pkg::ST_SET_T: begin
            mul_req = '{start: !pend_ff, a: t_ff, b: t_ff};
            pend_in = 1'b1;
            if (mul_rsp.done) begin
               pend_in  = 1'b0;
               tt_in    = mul_rsp.value;
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = fdbvp_pkg::ST_SET_R;
            end
         end
         fdbvp_pkg::ST_SET_R: begin
            mul_req = '{start: !pend_ff, a: h2_ff, b: tt_ff};
            pend_in = 1'b1;
            if (mul_rsp.done) begin
               pend_in = 1'b0;
               r       = mul_rsp.value;
               sat_in  = sat_ff | mul_rsp.sat;
               // take the boundary terms off the end rows
               if (idx_ff == '0) begin
                  sr     = fdbvp_pkg::sat_sub(r, x1_ff);
                  r      = sr[fdbvp_pkg::QW-1:0];
                  sat_in = sat_in | sr[fdbvp_pkg::QW];
                  rprev_in = r;
               end
               if (idx_ff == LAST_IDX) begin
                  sr     = fdbvp_pkg::sat_sub(r, x2_ff);
                  r      = sr[fdbvp_pkg::QW-1:0];
                  sat_in = sat_in | sr[fdbvp_pkg::QW];
               end
               mem_we  = 1'b1;
               diag_wd = fdbvp_pkg::Q_NEG_TWO;
               rhs_wd  = r;
               if (idx_ff == '0) begin
                  rprev_in = r;
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  d_in     = fdbvp_pkg::Q_NEG_TWO;
                  state_in = fdbvp_pkg::ST_ELIM_INV;
               end else begin
                  idx_in   = idx_ff + fdbvp_pkg::IDX_W'(1);
                  t_in     = t_ff + h_ff;
                  state_in = fdbvp_pkg::ST_SET_T;
               end
            end
         end
         fdbvp_pkg::ST_ELIM_INV: begin
            mem_ra  = idx_ff + fdbvp_pkg::IDX_W'(1);
            div_req = '{start: !pend_ff, a: fdbvp_pkg::Q_ONE, b: d_ff};
            pend_in = 1'b1;
            if (div_rsp.done) begin
               pend_in = 1'b0;
               sr      = fdbvp_pkg::sat_sub(fdbvp_pkg::Q_NEG_TWO, div_rsp.value);
               sat_in  = sat_ff | div_rsp.sat | sr[fdbvp_pkg::QW];
               dnew_in = sr[fdbvp_pkg::QW-1:0];
               if (sr[fdbvp_pkg::QW-1:0] == '0) begin
                  // zero pivot: drop the solve and report failure
                  rsp_idx_in  = 6'd0;
                  rsp_val_in  = 32'd0;
                  rsp_last_in = 1'b1;
                  rsp_stat_in = fdbvp_pkg::STATUS_FAIL;
                  state_in    = fdbvp_pkg::ST_FAIL_HOLD;
               end else begin
                  state_in = fdbvp_pkg::ST_ELIM_RHS;
               end
            end
         end
         fdbvp_pkg::ST_ELIM_RHS: begin
            mem_ra  = idx_ff + fdbvp_pkg::IDX_W'(1);
            div_req = '{start: !pend_ff, a: rprev_ff, b: d_ff};
            pend_in = 1'b1;
            if (div_rsp.done) begin
               pend_in  = 1'b0;
               sr       = fdbvp_pkg::sat_sub(rhs_rd_ff, div_rsp.value);
               sat_in   = sat_ff | div_rsp.sat | sr[fdbvp_pkg::QW];
               mem_we   = 1'b1;
               mem_wa   = idx_ff + fdbvp_pkg::IDX_W'(1);
               diag_wd  = dnew_ff;
               rhs_wd   = sr[fdbvp_pkg::QW-1:0];
               d_in     = dnew_ff;
               rprev_in = sr[fdbvp_pkg::QW-1:0];
               if (idx_ff + fdbvp_pkg::IDX_W'(1) == LAST_IDX) begin
                  idx_in   = LAST_IDX;
                  state_in = fdbvp_pkg::ST_BACK_RD;
               end else begin
                  idx_in   = idx_ff + fdbvp_pkg::IDX_W'(1);
                  state_in = fdbvp_pkg::ST_ELIM_INV;
               end
            end
         end
         fdbvp_pkg::ST_BACK_RD: begin
            state_in = fdbvp_pkg::ST_BACK_DIV;
         end
         fdbvp_pkg::ST_BACK_DIV: begin
            sr      = fdbvp_pkg::sat_sub(rhs_rd_ff, (idx_ff == LAST_IDX) ? '0 : nxt_ff);
            div_req = '{start: !pend_ff, a: sr[fdbvp_pkg::QW-1:0], b: diag_rd_ff};
            pend_in = 1'b1;
            if (!pend_ff) begin
               sat_in = sat_ff | sr[fdbvp_pkg::QW];
            end
            if (div_rsp.done) begin
               pend_in  = 1'b0;
               x        = div_rsp.value;
               nxt_in   = x;
               in_range = (x[fdbvp_pkg::QW-1:31] == '0) || (x[fdbvp_pkg::QW-1:31] == '1);
               sat_in   = sat_ff | div_rsp.sat | !in_range;
               // keep the clamped 32-bit result in place of the spent rhs entry
               mem_we   = 1'b1;
               diag_wd  = diag_rd_ff;
               rhs_wd   = in_range ? x :
                          (x[fdbvp_pkg::QW-1] ? fdbvp_pkg::q_type'(-64'sd2147483648)
                                              : fdbvp_pkg::q_type'(64'sd2147483647));
               if (idx_ff == '0) begin
                  idx_in   = LAST_IDX;
                  state_in = fdbvp_pkg::ST_OUT_RD;
               end else begin
                  idx_in   = idx_ff - fdbvp_pkg::IDX_W'(1);
                  state_in = fdbvp_pkg::ST_BACK_RD;
               end
            end
         end
         fdbvp_pkg::ST_OUT_RD: begin
            state_in = fdbvp_pkg::ST_OUT_LOAD;
         end
         fdbvp_pkg::ST_OUT_LOAD: begin
            rsp_idx_in  = 6'(idx_ff);
            rsp_val_in  = rhs_rd_ff[31:0];
            rsp_last_in = (idx_ff == '0);
            rsp_stat_in = sat_ff ? fdbvp_pkg::STATUS_SAT : fdbvp_pkg::STATUS_OK;
            state_in    = fdbvp_pkg::ST_OUT_HOLD;
         end
         fdbvp_pkg::ST_OUT_HOLD: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               if (idx_ff == '0) begin
                  state_in = fdbvp_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff - fdbvp_pkg::IDX_W'(1);
                  state_in = fdbvp_pkg::ST_OUT_RD;
               end
            end
         end
         fdbvp_pkg::ST_FAIL_HOLD: begin
            rsp_if.valid = 1'b1;
            if (rsp_if.ready) begin
               state_in = fdbvp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdbvp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_if.point_index = rsp_idx_ff;
   assign rsp_if.point_value = rsp_val_ff;
   assign rsp_if.last_point  = rsp_last_ff;
   assign rsp_if.status      = rsp_stat_ff;

endmodule
